>>> sv/ecpe_pkg.sv
package ecpe_pkg;

  localparam int XY_BITS     = 8;
  localparam int VALUE_BITS  = 16;
  localparam int THR_BITS    = 15;
  localparam int PORT_TIME   = 48;
  localparam int DELTA_BITS  = 32;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CFG_IDX_BITS-1:0] CFG_POS_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NEG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REFRACTORY    = 2'd2;

  localparam logic [THR_BITS-1:0]   POS_THRESHOLD_RST = 15'd2458;
  localparam logic [THR_BITS-1:0]   NEG_THRESHOLD_RST = 15'd2458;
  localparam logic [DELTA_BITS-1:0] REFRACTORY_RST    = 32'd100000;

  typedef struct packed {
    logic [XY_BITS-1:0]           pixel_x;
    logic [XY_BITS-1:0]           pixel_y;
    logic signed [VALUE_BITS-1:0] log_value;
    logic [PORT_TIME-1:0]         frame_time;
    logic [DELTA_BITS-1:0]        frame_delta;
    logic                         frame_end;
  } pixel_t;

  typedef struct packed {
    logic [PORT_TIME-1:0] event_time;
    logic [XY_BITS-1:0]   event_x;
    logic [XY_BITS-1:0]   event_y;
    logic                 polarity;
    logic                 suppressed;
    logic                 last_of_pixel;
    logic                 truncated;
  } event_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_COMPARE,
    ST_HIT,
    ST_DIVIDE,
    ST_TIME,
    ST_SUPPRESS,
    ST_WRITE
  } state_t;

endpackage

>>> sv/ecpe_ifs.sv
interface ecpe_pixel_if import ecpe_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface ecpe_event_if import ecpe_pkg::*; ();
  logic   valid;
  logic   ready;
  event_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface ecpe_cfg_if import ecpe_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

>>> sv/ecpe_ram.sv
module ecpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/ecpe_div.sv
module ecpe_div import ecpe_pkg::*; #(
  parameter int TIME_BITS = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] num,
  input  logic [VALUE_BITS-1:0] den,
  input  logic [TIME_BITS-1:0]  scale,
  output logic                  done,
  output logic [TIME_BITS-1:0]  quot
);

  localparam int CNT_BITS = $clog2(TIME_BITS);

  logic                  busy;
  logic [CNT_BITS-1:0]   cnt;
  logic [TIME_BITS-1:0]  scale_sh;
  logic [VALUE_BITS-1:0] num_r;
  logic [VALUE_BITS-1:0] rem;
  logic [VALUE_BITS+1:0] acc;
  logic [VALUE_BITS+1:0] den1;
  logic [VALUE_BITS+1:0] den2;
  logic [VALUE_BITS-1:0] rem_next;
  logic [1:0]            digit;

  assign den1 = {2'b00, den};
  assign den2 = {1'b0, den, 1'b0};

  always_comb begin
    acc = {1'b0, rem, 1'b0} + (scale_sh[TIME_BITS-1] ? {2'b00, num_r} : '0);
    if (acc >= den2) begin
      rem_next = VALUE_BITS'(acc - den2);
      digit    = 2'd2;
    end else if (acc >= den1) begin
      rem_next = VALUE_BITS'(acc - den1);
      digit    = 2'd1;
    end else begin
      rem_next = VALUE_BITS'(acc);
      digit    = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt      <= CNT_BITS'(TIME_BITS - 1);
      scale_sh <= scale;
      num_r    <= num;
      rem      <= '0;
      quot     <= '0;
    end else if (busy) begin
      cnt      <= cnt - 1'b1;
      scale_sh <= {scale_sh[TIME_BITS-2:0], 1'b0};
      rem      <= rem_next;
      quot     <= {quot[TIME_BITS-2:0], 1'b0} + TIME_BITS'(digit);
    end
  end

endmodule

>>> sv/event_camera_pixel_emulator.sv
// Steps: an unchanged pixel passes IDLE, READ, COMPARE and WRITE; a changed pixel with no
//   crossing also passes HIT; a first-frame or off-frame pixel goes from IDLE to WRITE.
// Each crossing adds HIT, DIVIDE (waiting on the bit-serial interpolation divider), TIME
//   and SUPPRESS, and HIT waits while the event output is stalled.
// A new pixel is taken only in IDLE, so each pixel finishes before the next is accepted.
// Reset: synchronous; clears control, config and time base; pixel memory is not cleared.
module event_camera_pixel_emulator import ecpe_pkg::*; #(
  parameter int FRAME_WIDTH   = 256,
  parameter int FRAME_HEIGHT  = 256,
  parameter int MAX_CROSSINGS = 64,
  parameter int TIME_BITS     = 48
) (
  input  logic        clk,
  input  logic        rst,
  ecpe_pixel_if.sink  pix,
  ecpe_event_if.source evt,
  ecpe_cfg_if.sink    cfg
);

  localparam int NPIX     = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int IDX_BITS = (NPIX > 1) ? $clog2(NPIX) : 1;
  localparam int N_BITS   = $clog2(MAX_CROSSINGS + 1);
  localparam int RAM_W    = 2 * VALUE_BITS + TIME_BITS;

  state_t state, state_next;

  logic [THR_BITS-1:0]   pos_threshold;
  logic [THR_BITS-1:0]   neg_threshold;
  logic [DELTA_BITS-1:0] refractory_ns;
  logic [TIME_BITS-1:0]  current_time;
  logic                  initialized;

  logic [XY_BITS-1:0]           x_r, y_r;
  logic signed [VALUE_BITS-1:0] nv;
  logic [TIME_BITS-1:0]         ftime;
  logic [DELTA_BITS-1:0]        fdelta;
  logic                         fend;
  logic                         in_range;
  logic [IDX_BITS-1:0]          idx;

  logic signed [VALUE_BITS-1:0] old_r, cur;
  logic [TIME_BITS-1:0]         stamp;
  logic                         rise;
  logic [THR_BITS-1:0]          step;
  logic [VALUE_BITS-1:0]        span;
  logic [TIME_BITS-1:0]         interval;
  logic [N_BITS-1:0]            n;
  logic [VALUE_BITS-1:0]        part;
  logic [TIME_BITS-1:0]         t_r;

  logic                 pend;
  logic [TIME_BITS-1:0] pend_t;
  logic                 pend_sup;

  logic                         accept;
  logic                         pix_in_range;
  logic [IDX_BITS-1:0]          pix_idx;
  logic signed [VALUE_BITS+1:0] next_lv;
  logic                         hit;
  logic                         cap;
  logic                         emit_ok;
  logic                         push;
  logic                         push_last;
  logic                         div_start;
  logic                         div_done;
  logic [TIME_BITS-1:0]         div_q;
  logic                         ram_we;
  logic [RAM_W-1:0]             ram_wdata;
  logic [RAM_W-1:0]             ram_rdata;
  logic signed [VALUE_BITS-1:0] rd_old, rd_ref;
  logic [TIME_BITS-1:0]         rd_stamp;
  logic [TIME_BITS-1:0]         dt;
  logic                         sup;

  assign cfg.ready = 1'b1;
  assign accept    = pix.valid && pix.ready;

  assign pix_in_range = (32'(pix.data.pixel_x) < FRAME_WIDTH)
                     && (32'(pix.data.pixel_y) < FRAME_HEIGHT);
  assign pix_idx = IDX_BITS'(32'(pix.data.pixel_y) * FRAME_WIDTH + 32'(pix.data.pixel_x));

  assign rd_old   = ram_rdata[RAM_W-1 -: VALUE_BITS];
  assign rd_ref   = ram_rdata[TIME_BITS +: VALUE_BITS];
  assign rd_stamp = ram_rdata[TIME_BITS-1:0];

  assign next_lv = rise ? (VALUE_BITS+2)'(cur) + $signed({3'b000, step})
                        : (VALUE_BITS+2)'(cur) - $signed({3'b000, step});
  assign hit = rise ? (next_lv > (VALUE_BITS+2)'(old_r) && next_lv <= (VALUE_BITS+2)'(nv))
                    : (next_lv < (VALUE_BITS+2)'(old_r) && next_lv >= (VALUE_BITS+2)'(nv));
  assign cap  = (n == N_BITS'(MAX_CROSSINGS));
  assign part = rise ? VALUE_BITS'(next_lv - (VALUE_BITS+2)'(old_r))
                     : VALUE_BITS'((VALUE_BITS+2)'(old_r) - next_lv);
  assign emit_ok = !evt.valid || evt.ready;

  assign dt  = t_r - stamp;
  assign sup = !(stamp == '0 || dt >= TIME_BITS'(refractory_ns));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!pix_in_range || !initialized) state_next = ST_WRITE;
          else state_next = ST_READ;
        end
      end
      ST_READ:    state_next = ST_COMPARE;
      ST_COMPARE: state_next = (nv == rd_old) ? ST_WRITE : ST_HIT;
      ST_HIT: begin
        if (!pend || emit_ok) begin
          state_next = (hit && !cap) ? ST_DIVIDE : ST_WRITE;
        end
      end
      ST_DIVIDE:   if (div_done) state_next = ST_TIME;
      ST_TIME:     state_next = ST_SUPPRESS;
      ST_SUPPRESS: state_next = ST_HIT;
      ST_WRITE:    state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pix.ready = 1'b0;
    push      = 1'b0;
    push_last = 1'b0;
    div_start = 1'b0;
    ram_we    = 1'b0;
    unique case (state)
      ST_IDLE: pix.ready = 1'b1;
      ST_HIT: begin
        if (!pend || emit_ok) begin
          push      = pend;
          push_last = !(hit && !cap);
          div_start = hit && !cap;
        end
      end
      ST_WRITE: ram_we = in_range;
      default: ;
    endcase
  end

  always_comb begin
    if (!initialized) begin
      ram_wdata = {nv, nv, {TIME_BITS{1'b0}}};
    end else begin
      ram_wdata = {nv, cur, stamp};
    end
  end

  ecpe_ram #(
    .WIDTH(RAM_W),
    .DEPTH(NPIX)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx),
    .wdata(ram_wdata),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  ecpe_div #(
    .TIME_BITS(TIME_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (part),
    .den  (span),
    .scale(interval),
    .done (div_done),
    .quot (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      pos_threshold <= POS_THRESHOLD_RST;
      neg_threshold <= NEG_THRESHOLD_RST;
      refractory_ns <= REFRACTORY_RST;
      current_time  <= '0;
      initialized   <= 1'b0;
      evt.valid     <= 1'b0;
      pend          <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          CFG_POS_THRESHOLD: pos_threshold <= cfg.data[THR_BITS-1:0];
          CFG_NEG_THRESHOLD: neg_threshold <= cfg.data[THR_BITS-1:0];
          CFG_REFRACTORY:    refractory_ns <= cfg.data[DELTA_BITS-1:0];
          default: ;
        endcase
      end
      if (state == ST_WRITE && fend) begin
        if (!initialized) begin
          initialized  <= 1'b1;
          current_time <= ftime;
        end else if (fdelta != '0) begin
          current_time <= current_time + TIME_BITS'(fdelta);
        end else begin
          current_time <= ftime;
        end
      end
      if (push) begin
        evt.valid <= 1'b1;
      end else if (evt.ready) begin
        evt.valid <= 1'b0;
      end
      if (accept) begin
        pend <= 1'b0;
      end else if (push) begin
        pend <= 1'b0;
      end else if (state == ST_SUPPRESS) begin
        pend <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r      <= pix.data.pixel_x;
      y_r      <= pix.data.pixel_y;
      nv       <= pix.data.log_value;
      ftime    <= TIME_BITS'(pix.data.frame_time);
      fdelta   <= pix.data.frame_delta;
      fend     <= pix.data.frame_end;
      in_range <= pix_in_range;
      idx      <= pix_idx;
      n        <= '0;
    end
    unique case (state)
      ST_COMPARE: begin
        old_r    <= rd_old;
        cur      <= rd_ref;
        stamp    <= rd_stamp;
        rise     <= nv >= rd_old;
        if (nv >= rd_old) begin
          step <= (pos_threshold == '0) ? THR_BITS'(1) : pos_threshold;
          span <= VALUE_BITS'(nv - rd_old);
        end else begin
          step <= (neg_threshold == '0) ? THR_BITS'(1) : neg_threshold;
          span <= VALUE_BITS'(rd_old - nv);
        end
        interval <= (fdelta != '0) ? TIME_BITS'(fdelta) : ftime - current_time;
      end
      ST_HIT: begin
        if (div_start) cur <= VALUE_BITS'(next_lv);
      end
      ST_TIME: t_r <= current_time + div_q;
      ST_SUPPRESS: begin
        if (!sup) stamp <= t_r;
        pend_t   <= t_r;
        pend_sup <= sup;
        n        <= n + 1'b1;
      end
      default: ;
    endcase
    if (push) begin
      evt.data.event_time    <= PORT_TIME'(pend_t);
      evt.data.event_x       <= x_r;
      evt.data.event_y       <= y_r;
      evt.data.polarity      <= rise;
      evt.data.suppressed    <= pend_sup;
      evt.data.last_of_pixel <= push_last;
      evt.data.truncated     <= push_last && hit && cap;
    end
  end

endmodule

>>> sv/ecpe_checker.sv
module ecpe_checker import ecpe_pkg::*; (
  input logic clk,
  input logic rst,
  input logic pix_valid,
  input logic pix_ready,
  input logic evt_valid,
  input logic evt_ready,
  input event_t evt_data
);

  assert property (@(posedge clk) disable iff (rst)
    evt_valid && !evt_ready |=> evt_valid && $stable(evt_data))
    else $error("event changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_ready |=> !pix_ready)
    else $error("pixel taken while busy");

  assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_data.truncated |-> evt_data.last_of_pixel)
    else $error("truncation flag on non-final event");

  assert property (@(posedge clk)
    rst |=> !evt_valid)
    else $error("event valid after reset");

endmodule

bind event_camera_pixel_emulator ecpe_checker u_ecpe_checker (
  .clk      (clk),
  .rst      (rst),
  .pix_valid(pix.valid),
  .pix_ready(pix.ready),
  .evt_valid(evt.valid),
  .evt_ready(evt.ready),
  .evt_data (evt.data)
);
